### design/pcxrle_pkg.sv
package pcxrle_pkg;

    // Run limits and count byte marker
    localparam logic [5:0] RUN_MAX    = 6'h3F;
    localparam logic [7:0] COUNT_MARK = 8'hC0;

    // Results per item and output queue geometry
    localparam int MAX_RES    = 4;
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int RES_W      = $clog2(MAX_RES + 1);

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [RES_W-1:0] t_res_cnt;

    // One encoded run: one or two bytes, or none when disabled
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [1:0] n;
    } t_run;

    // Everything one item yields: bytes, their count, line end, next state
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        t_res_cnt                count;
        logic                    last;
        logic [7:0]              held;
        logic [5:0]              len;
        logic                    open;
    } t_enc_res;

    // Queue entry
    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } t_entry;

    // Encode one run: count byte only for runs above one or when the
    // inverted byte would look like a count byte itself
    function automatic t_run make_run(input logic [7:0] data, input logic [5:0] count,
                                      input logic en);
        t_run       r;
        logic [7:0] inv;
        inv = ~data;
        r   = '0;
        if (en) begin
            if ((inv[7:6] == 2'b11) || (count > 6'd1)) begin
                r.b0 = COUNT_MARK | {2'b00, count};
                r.b1 = inv;
                r.n  = 2'd2;
            end else begin
                r.b0 = inv;
                r.b1 = 8'h00;
                r.n  = 2'd1;
            end
        end
        return r;
    endfunction

endpackage

### design/pcxrle_encode.sv
module pcxrle_encode
    import pcxrle_pkg::*;
(
    input  logic       i_open,
    input  logic [7:0] i_held,
    input  logic [5:0] i_len,
    input  logic [7:0] i_byte,
    input  logic       i_line_end,
    output t_enc_res   o_res
);

    logic [5:0] len_inc;
    logic [7:0] mid_held;
    logic [5:0] mid_len;
    logic [7:0] run1_data;
    logic [5:0] run1_cnt;
    logic       run1_en;
    t_run       run1;
    t_run       run2;

    assign len_inc = i_len + 6'd1;

    // Run update for the incoming byte
    always_comb begin
        run1_data = i_held;
        run1_cnt  = i_len;
        run1_en   = 1'b0;
        mid_held  = i_byte;
        mid_len   = 6'd1;
        if (i_open && (i_byte == i_held)) begin
            mid_held = i_held;
            if (len_inc == RUN_MAX) begin
                // full run goes out at once
                run1_cnt = RUN_MAX;
                run1_en  = 1'b1;
                mid_len  = 6'd0;
            end else begin
                mid_len = len_inc;
            end
        end else if (i_open) begin
            // different byte closes the current run
            run1_en = (i_len != 6'd0);
        end
    end

    assign run1 = make_run(run1_data, run1_cnt, run1_en);
    // flush at line end
    assign run2 = make_run(mid_held, mid_len, i_line_end && (mid_len != 6'd0));

    // Pack both runs into consecutive slots
    always_comb begin
        o_res.bytes = '0;
        case (run1.n)
            2'd1: begin
                o_res.bytes[0] = run1.b0;
                o_res.bytes[1] = run2.b0;
                o_res.bytes[2] = run2.b1;
            end
            2'd2: begin
                o_res.bytes[0] = run1.b0;
                o_res.bytes[1] = run1.b1;
                o_res.bytes[2] = run2.b0;
                o_res.bytes[3] = run2.b1;
            end
            default: begin
                o_res.bytes[0] = run2.b0;
                o_res.bytes[1] = run2.b1;
            end
        endcase
        o_res.count = RES_W'(run1.n) + RES_W'(run2.n);
        o_res.last  = i_line_end;
        if (i_line_end) begin
            o_res.held = 8'h00;
            o_res.len  = 6'd0;
            o_res.open = 1'b0;
        end else begin
            o_res.held = mid_held;
            o_res.len  = mid_len;
            o_res.open = 1'b1;
        end
    end

endmodule

### design/pcxrle_line_encoder_top.sv
// Run-length encoder for raster scan lines with inverted data bytes.
// Input channel: one raster byte per transfer (i_in_byte), with i_in_line_end
// set on the final byte of a scan line. Output channel: one encoded byte per
// transfer (o_out_byte), o_out_last set on the final encoded byte of the line.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low.
// An input byte is registered in the input stage, then encoded into the
// eight-entry output queue once the queue has room for a full result set;
// its results are then presented at the queue head in order.
// An input byte yields zero to four encoded bytes.
// Throughput: one input byte per cycle while the queue has room for four more
// entries; the output port drains one byte per cycle while the receiver does
// not stall, so a stream is bound by the encoded bytes per input byte (two
// at worst for a running stream, four at a line end).
// Reset (synchronous, active low) empties the queue and the input register and
// returns the run state to awaiting the first byte of a line.
// When the receiver stalls, the head byte holds; the queue fills and then the
// input stage stalls, losing nothing.
module pcx_rle_line_encoder_top
    import pcxrle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_line_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic [7:0] r_held;
    logic [5:0] r_len;
    logic       r_open;
    t_entry     r_mem [FIFO_DEPTH];
    t_ptr       r_wr_ptr;
    t_ptr       r_rd_ptr;
    t_cnt       r_cnt;
    t_cnt       n_cnt;
    t_enc_res   enc_res;
    logic       proc;
    logic       in_xfer;
    logic       pop;

    // Process the staged byte when the queue can take a full result set
    assign proc       = r_in_valid && (r_cnt <= CNT_W'(FIFO_DEPTH - MAX_RES));
    assign o_in_stall = r_in_valid && !proc;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign pop        = o_out_valid && !i_out_stall;

    pcxrle_encode u_encode (
        .i_open     (r_open),
        .i_held     (r_held),
        .i_len      (r_len),
        .i_byte     (r_in_byte),
        .i_line_end (r_in_last),
        .o_res      (enc_res)
    );

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
        if (in_xfer) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_line_end;
        end
    end

    // Run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 8'h00;
            r_len  <= 6'd0;
            r_open <= 1'b0;
        end else if (proc) begin
            r_held <= enc_res.held;
            r_len  <= enc_res.len;
            r_open <= enc_res.open;
        end
    end

    // Output queue storage
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (proc && (RES_W'(k) < enc_res.count)) begin
                r_mem[r_wr_ptr + PTR_W'(k)] <= '{
                    last: enc_res.last && (RES_W'(k) == enc_res.count - RES_W'(1)),
                    data: enc_res.bytes[k]
                };
            end
        end
    end

    // Queue pointers and fill count
    always_comb begin
        n_cnt = r_cnt;
        if (proc) begin
            n_cnt = n_cnt + CNT_W'(enc_res.count);
        end
        if (pop) begin
            n_cnt = n_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (proc) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(enc_res.count);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    assign o_out_valid = (r_cnt != '0);
    assign o_out_byte  = r_mem[r_rd_ptr].data;
    assign o_out_last  = r_mem[r_rd_ptr].last;

endmodule

### design/pcxrle_checker.sv
module pcxrle_checker
    import pcxrle_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [7:0] i_in_byte,
    input logic       i_in_line_end,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_out_last
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_out_last))
        else $error("stalled output changed");

    // A stalled input transfer holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_byte)
            && $stable(i_in_line_end))
        else $error("stalled input changed");

    // Reset empties the output queue
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Reset empties the input stage
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

    // When the output is empty and neither that cycle nor the one before it held
    // an input transfer, nothing is left to show a result on the next cycle
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_valid && !o_in_stall)
            ##1 (!o_out_valid && !(i_in_valid && !o_in_stall)) |=> !o_out_valid)
        else $error("result appeared without a pending item");

endmodule

bind pcx_rle_line_encoder_top pcxrle_checker u_pcxrle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_in_byte     (i_in_byte),
    .i_in_line_end (i_in_line_end),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_byte    (o_out_byte),
    .o_out_last    (o_out_last)
);
